// File: hw/rtl/coo_to_csc_builder_assert.svh
// Assertion macros used by the checker file.
`ifndef COO_TO_CSC_BUILDER_ASSERT_SVH
`define COO_TO_CSC_BUILDER_ASSERT_SVH
`define CCB_ASSERT_IMPL(label, clk, rst_n, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
`define CCB_ASSERT_NEXT(label, clk, rst_n, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`endif

// File: hw/rtl/ccb_pkg.sv
`timescale 1ns / 1ps
package ccb_pkg;
  localparam int MAX_ENTRIES = 2048;
  localparam int MAX_DIMENSION = 65536;
  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int CW = AW + 1;

  localparam logic [1:0] MODE_LOAD = 2'd0;
  localparam logic [1:0] MODE_READ = 2'd1;
  localparam logic [1:0] MODE_START = 2'd2;
  localparam logic [1:0] MODE_CLEAR = 2'd3;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_BEYOND = 2'd3;

  localparam logic [1:0] CFG_ROWS = 2'd0;
  localparam logic [1:0] CFG_COLS = 2'd1;
  localparam logic [1:0] CFG_SYM = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_SHIFT, S_PUT, S_READ, S_DONE
  } state_t;

  // One memory access request from the sequencer.
  typedef struct packed {
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [31:0]   wr_key;
    logic [63:0]   wr_val;
  } mem_req_t;
endpackage

// File: hw/rtl/ccb_store.sv
`timescale 1ns / 1ps
module ccb_store (
  input  logic                  clk,
  input  ccb_pkg::mem_req_t     req,
  output logic [31:0]           rd_key,
  output logic [63:0]           rd_val
);
  logic [95:0] mem [ccb_pkg::MAX_ENTRIES];
  logic [95:0] rd_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= {req.wr_key, req.wr_val};
    end
    if (req.rd_en) begin
      rd_r <= mem[req.rd_addr];
    end
  end

  assign rd_key = rd_r[95:64];
  assign rd_val = rd_r[63:0];
endmodule

// File: hw/rtl/coo_to_csc_builder.sv
`timescale 1ns / 1ps
// Sorted sparse-entry store with a start/busy command port.
// Drive start with mode and operands while busy is low; the item is taken
// at that edge and busy rises. Exactly one result follows, marked by
// out_valid for one cycle in which busy is already low, so the next item can
// be taken at the edge that ends the result beat. The receiver cannot stall.
// Load: a scan reads the stored entries up to the insert slot, then the tail
// moves up one place per step, each a read and then a write; a mirrored
// pair does this twice. A rejected load goes straight to the done state,
// and a column start scans every stored entry. All timing is set by the
// single read and single write port of the store.
// Reset sets the state, count, flag and config registers to their defaults
// and empties the store; memory contents are not cleared because nothing
// beyond the count is readable.
// Config writes go through cfg_we / cfg_index / cfg_data; the user must make
// them only at an idle edge, as the block itself does not enforce this.
module coo_to_csc_builder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_mode,
  input  logic [16:0] in_row_number,
  input  logic [16:0] in_column_number,
  input  logic [63:0] in_value_bits,
  input  logic [10:0] in_read_index,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [16:0] cfg_data,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [15:0] out_row_index,
  output logic [15:0] out_column_index,
  output logic [63:0] out_value_out,
  output logic [11:0] out_column_start,
  output logic [11:0] out_stored_total
);
  ccb_pkg::mem_req_t req;
  logic [31:0] rd_key;
  logic [63:0] rd_val;

  ccb_store u_store (.clk(clk), .req(req), .rd_key(rd_key), .rd_val(rd_val));

  logic [16:0] rows_r, cols_r;
  logic        sym_r;
  ccb_pkg::state_t st_r, st_nxt;
  logic [ccb_pkg::CW-1:0] total_r, total_nxt;
  logic [ccb_pkg::CW-1:0] idx_r, idx_nxt;     // scan position / shift position
  logic          pend_r, pend_nxt;   // read data pending from the store
  logic          found_r, found_nxt;
  logic [ccb_pkg::CW-1:0] cnt_r, cnt_nxt;
  logic [1:0]  mode_r;
  logic [31:0] key_r, key_nxt;       // key of the copy being inserted
  logic [31:0] key2_r;
  logic        second_r, second_nxt; // mirror copy still to insert
  logic [63:0] val_r;
  logic [16:0] ccol_r;
  logic        ov_r, ov_nxt;
  logic [1:0]  os_r, os_nxt;
  logic [15:0] orow_r, orow_nxt, ocol_r, ocol_nxt;
  logic [63:0] oval_r, oval_nxt;
  logic [11:0] ostart_r, ostart_nxt;

  // Decode of a new item.
  logic acc, mirror, bad_ld, full_ld, bad_start;
  logic [15:0] r0, c0;
  function automatic logic fits(input logic [16:0] n, input logic [16:0] lim);
    fits = (n != 17'd0) && (n <= lim) && (n <= 17'(ccb_pkg::MAX_DIMENSION));
  endfunction
  assign acc    = start && !busy;
  assign mirror = sym_r && (in_row_number != in_column_number);
  assign bad_ld = !fits(in_row_number, rows_r) || !fits(in_column_number, cols_r) ||
                  (mirror && (!fits(in_column_number, rows_r) ||
                              !fits(in_row_number, cols_r)));
  assign full_ld = ({1'b0, total_r} + (mirror ? 13'd2 : 13'd1)) >
                   13'(ccb_pkg::MAX_ENTRIES);
  assign bad_start = (in_column_number > cols_r) ||
                     (in_column_number > 17'(ccb_pkg::MAX_DIMENSION));
  assign r0 = 16'(in_row_number - 17'd1);
  assign c0 = 16'(in_column_number - 17'd1);

  assign busy = (st_r != ccb_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= 17'd65536;
      cols_r <= 17'd65536;
      sym_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        ccb_pkg::CFG_ROWS: rows_r <= cfg_data;
        ccb_pkg::CFG_COLS: cols_r <= cfg_data;
        ccb_pkg::CFG_SYM:  sym_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Next state.
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ccb_pkg::S_IDLE: begin
        if (acc) begin
          case (in_mode)
            ccb_pkg::MODE_LOAD:
              st_nxt = (bad_ld || full_ld) ? ccb_pkg::S_DONE : ccb_pkg::S_SCAN;
            ccb_pkg::MODE_READ:
              st_nxt = ({1'b0, in_read_index} >= total_r) ? ccb_pkg::S_DONE
                                                            : ccb_pkg::S_READ;
            ccb_pkg::MODE_START:
              st_nxt = bad_start ? ccb_pkg::S_DONE : ccb_pkg::S_SCAN;
            default: st_nxt = ccb_pkg::S_DONE;
          endcase
        end
      end
      ccb_pkg::S_SCAN: begin
        if (found_nxt || (!pend_r && idx_r >= total_r) ||
            (pend_r && idx_r >= total_r)) begin
          if (!pend_r && idx_r >= total_r) begin
            st_nxt = (mode_r == ccb_pkg::MODE_LOAD) ? ccb_pkg::S_SHIFT
                                                   : ccb_pkg::S_DONE;
          end else if (found_nxt) begin
            st_nxt = ccb_pkg::S_SHIFT;
          end
        end
      end
      ccb_pkg::S_SHIFT: begin
        if (!pend_r && idx_nxt == cnt_r) st_nxt = ccb_pkg::S_PUT;
      end
      ccb_pkg::S_PUT:  st_nxt = second_r ? ccb_pkg::S_SCAN : ccb_pkg::S_DONE;
      ccb_pkg::S_READ: st_nxt = pend_r ? ccb_pkg::S_DONE : ccb_pkg::S_READ;
      ccb_pkg::S_DONE: st_nxt = ccb_pkg::S_IDLE;
      default: st_nxt = ccb_pkg::S_IDLE;
    endcase
  end

  // Datapath and memory control.
  // In SCAN, idx_r is the next address to read; pend_r means the data of
  // address idx_r-1 is on rd_key. For a load, cnt_r latches the insert slot.
  // In SHIFT, idx_r walks down from total; each step reads idx-1 then
  // writes it to idx.
  always_comb begin
    total_nxt = total_r;
    idx_nxt = idx_r;
    pend_nxt = 1'b0;
    found_nxt = found_r;
    cnt_nxt = cnt_r;
    key_nxt = key_r;
    second_nxt = second_r;
    ov_nxt = 1'b0;
    os_nxt = os_r;
    orow_nxt = orow_r;
    ocol_nxt = ocol_r;
    oval_nxt = oval_r;
    ostart_nxt = ostart_r;
    req = '0;
    case (st_r)
      ccb_pkg::S_IDLE: begin
        if (acc) begin
          idx_nxt = '0;
          found_nxt = 1'b0;
          cnt_nxt = '0;
          key_nxt = {c0, r0};
          second_nxt = mirror;
          os_nxt = ccb_pkg::ST_OK;
          orow_nxt = '0;
          ocol_nxt = '0;
          oval_nxt = '0;
          ostart_nxt = '0;
          case (in_mode)
            ccb_pkg::MODE_LOAD: begin
              if (bad_ld) os_nxt = ccb_pkg::ST_RANGE;
              else if (full_ld) os_nxt = ccb_pkg::ST_FULL;
            end
            ccb_pkg::MODE_READ: begin
              if ({1'b0, in_read_index} >= total_r) os_nxt = ccb_pkg::ST_BEYOND;
              else begin
                req.rd_en = 1'b1;
                req.rd_addr = in_read_index;
              end
            end
            ccb_pkg::MODE_START: begin
              if (bad_start) os_nxt = ccb_pkg::ST_RANGE;
            end
            default: total_nxt = '0;
          endcase
        end
      end
      ccb_pkg::S_SCAN: begin
        if (pend_r) begin
          if (mode_r == ccb_pkg::MODE_LOAD) begin
            if (rd_key > key_r) begin
              found_nxt = 1'b1;
              cnt_nxt = idx_r - 1'b1;
            end
          end else if ({1'b0, rd_key[31:16]} < ccol_r) begin
            ostart_nxt = ostart_r + 12'd1;
          end
        end
        if (!found_nxt && idx_r < total_r) begin
          req.rd_en = 1'b1;
          req.rd_addr = idx_r[ccb_pkg::AW-1:0];
          idx_nxt = idx_r + 1'b1;
          pend_nxt = 1'b1;
        end
        if (!found_nxt && !pend_r && idx_r >= total_r) cnt_nxt = total_r;
        if (found_nxt || (!pend_r && idx_r >= total_r)) begin
          idx_nxt = total_r;
          pend_nxt = 1'b0;
        end
        if (!pend_r && idx_r >= total_r && mode_r != ccb_pkg::MODE_LOAD)
          ostart_nxt = ostart_r;
      end
      ccb_pkg::S_SHIFT: begin
        if (pend_r) begin
          req.wr_en = 1'b1;
          req.wr_addr = idx_r[ccb_pkg::AW-1:0];
          req.wr_key = rd_key;
          req.wr_val = rd_val;
          idx_nxt = idx_r - 1'b1;
        end else if (idx_r != cnt_r) begin
          req.rd_en = 1'b1;
          req.rd_addr = ccb_pkg::AW'(idx_r - 1'b1);
          pend_nxt = 1'b1;
        end
      end
      ccb_pkg::S_PUT: begin
        req.wr_en = 1'b1;
        req.wr_addr = cnt_r[ccb_pkg::AW-1:0];
        req.wr_key = key_r;
        req.wr_val = val_r;
        total_nxt = total_r + 1'b1;
        key_nxt = key2_r;
        second_nxt = 1'b0;
        idx_nxt = '0;
        found_nxt = 1'b0;
      end
      ccb_pkg::S_READ: begin
        if (pend_r) begin
          orow_nxt = rd_key[15:0];
          ocol_nxt = rd_key[31:16];
          oval_nxt = rd_val;
        end else begin
          pend_nxt = 1'b1;
        end
      end
      ccb_pkg::S_DONE: ov_nxt = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ccb_pkg::S_IDLE;
      total_r <= '0;
      pend_r <= 1'b0;
      ov_r <= 1'b0;
      second_r <= 1'b0;
      found_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      total_r <= total_nxt;
      pend_r <= (st_r == ccb_pkg::S_IDLE && acc && in_mode == ccb_pkg::MODE_READ &&
                 os_nxt == ccb_pkg::ST_OK) ? 1'b1 : pend_nxt;
      ov_r <= ov_nxt;
      second_r <= second_nxt;
      found_r <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    cnt_r <= cnt_nxt;
    key_r <= key_nxt;
    os_r <= os_nxt;
    orow_r <= orow_nxt;
    ocol_r <= ocol_nxt;
    oval_r <= oval_nxt;
    ostart_r <= ostart_nxt;
    if (acc) begin
      mode_r <= in_mode;
      key2_r <= {r0, c0};
      val_r <= in_value_bits;
      ccol_r <= in_column_number;
    end
  end

  assign out_valid = ov_r;
  assign out_status = os_r;
  assign out_row_index = orow_r;
  assign out_column_index = ocol_r;
  assign out_value_out = oval_r;
  assign out_column_start = ostart_r;
  assign out_stored_total = total_r;
endmodule

// File: hw/rtl/ccb_checker.sv
`timescale 1ns / 1ps
`include "coo_to_csc_builder_assert.svh"
module ccb_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [1:0]  out_status,
  input logic [11:0] out_stored_total,
  input logic [11:0] out_column_start
);
  // A result beat comes only once the busy period has ended.
  `CCB_ASSERT_IMPL(a_done, clk, rst_n, out_valid, !busy, "busy during result")
  // An accepted command raises busy.
  `CCB_ASSERT_NEXT(a_take, clk, rst_n, start && !busy, busy, "command not taken")
  // A result only comes out of a busy period.
  `CCB_ASSERT_IMPL(a_src, clk, rst_n, out_valid, $past(busy), "stray result")
  // The count never exceeds the store size.
  `CCB_ASSERT_IMPL(a_cap, clk, rst_n, 1'b1, out_stored_total <= 12'd2048, "count overflow")
  // A rejected item never reports a column pointer.
  `CCB_ASSERT_IMPL(a_err, clk, rst_n, out_valid && out_status != ccb_pkg::ST_OK, out_column_start == 12'd0, "pointer on error")
endmodule

bind coo_to_csc_builder ccb_checker u_ccb_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .out_valid(out_valid),
  .out_status(out_status), .out_stored_total(out_stored_total),
  .out_column_start(out_column_start)
);
